// ----- design/kse_pkg.sv -----
// Shared types, key codes and field widths for the keypad setpoint entry block.
package kse_pkg;

    localparam int KEY_W    = 4;
    localparam int LEN_W    = 3;
    localparam int DIGIT_W  = 4;
    localparam int TENTHS_W = 10;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 32;

    localparam logic [TENTHS_W-1:0] MIN_TARGET_RST = 10'd320;
    localparam logic [TENTHS_W-1:0] MAX_TARGET_RST = 10'd1000;
    localparam logic [TENTHS_W-1:0] SETPOINT_RST   = 10'd320;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TARGET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TARGET = 1'b1;

    // key codes, digits are their own value
    localparam logic [KEY_W-1:0] KEY_STAR = 4'd10;
    localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;
    localparam logic [KEY_W-1:0] KEY_A    = 4'd12;
    localparam logic [KEY_W-1:0] KEY_B    = 4'd13;
    localparam logic [KEY_W-1:0] KEY_C    = 4'd14;
    localparam logic [KEY_W-1:0] KEY_D    = 4'd15;

    localparam logic [LEN_W-1:0] LEN_POINT = 3'd2;
    localparam logic [LEN_W-1:0] LEN_AFTER_POINT = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FULL  = 3'd4;

    typedef struct packed {
        logic                  display_update;
        logic [TENTHS_W-1:0]   target_tenths;
        logic                  entry_ok;
        logic [DIGIT_W-1:0]    tenths_digit;
        logic [DIGIT_W-1:0]    units_digit;
        logic [DIGIT_W-1:0]    tens_digit;
        logic [LEN_W-1:0]      entry_length;
        logic                  in_entry_mode;
    } kse_result_t;

    // 4x4 keypad layout: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
    function automatic logic [KEY_W-1:0] key_map(input logic [1:0] row, input logic [1:0] col);
        logic [KEY_W-1:0] key;
        case ({row, col})
            4'h0: key = 4'd1;
            4'h1: key = 4'd2;
            4'h2: key = 4'd3;
            4'h3: key = KEY_A;
            4'h4: key = 4'd4;
            4'h5: key = 4'd5;
            4'h6: key = 4'd6;
            4'h7: key = KEY_B;
            4'h8: key = 4'd7;
            4'h9: key = 4'd8;
            4'hA: key = 4'd9;
            4'hB: key = KEY_C;
            4'hC: key = KEY_STAR;
            4'hD: key = 4'd0;
            4'hE: key = KEY_HASH;
            default: key = KEY_D;
        endcase
        return key;
    endfunction

endpackage

// ----- design/kse_step.sv -----
// Entry state, limit registers and the per-press next-state logic.
module kse_step
    import kse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  logic [1:0]            key_row,
    input  logic [1:0]            key_column,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output kse_result_t           result
);

    typedef enum logic [1:0] {
        ST_NORMAL = 2'b01,
        ST_ENTRY  = 2'b10
    } kse_state_t;

    kse_state_t              state_reg, state_next;
    logic [LEN_W-1:0]        count_reg, count_next;
    logic [DIGIT_W-1:0]      digit_reg [3];
    logic [DIGIT_W-1:0]      digit_next [3];
    logic                    valid_reg, valid_next;
    logic [TENTHS_W-1:0]     setpoint_reg, setpoint_next;
    logic [TENTHS_W-1:0]     min_reg, max_reg;

    logic [KEY_W-1:0]        key;
    logic                    fmt_ok;
    logic                    refresh;
    logic [TENTHS_W-1:0]     value;
    logic [1:0]              slot;

    assign key   = key_map(key_row, key_column);
    assign value = TENTHS_W'(digit_reg[0]) * 10'd100 + TENTHS_W'(digit_reg[1]) * 10'd10
                 + TENTHS_W'(digit_reg[2]);
    assign slot  = (count_reg == LEN_AFTER_POINT) ? 2'd2 : {1'b0, count_reg[0]};

    always_comb begin
        fmt_ok = 1'b1;
        if (key == KEY_B || key == KEY_C) begin
            fmt_ok = 1'b1;
        end else if (count_reg >= LEN_FULL && key != KEY_A) begin
            fmt_ok = 1'b0;
        end else if (count_reg == LEN_POINT && key != KEY_STAR) begin
            fmt_ok = 1'b0;
        end else if (key == KEY_D || key == KEY_HASH) begin
            fmt_ok = 1'b0;
        end else if (key == KEY_STAR && count_reg != LEN_POINT) begin
            fmt_ok = 1'b0;
        end else if (key == KEY_A && count_reg < LEN_FULL) begin
            fmt_ok = 1'b0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        digit_next    = digit_reg;
        valid_next    = valid_reg;
        setpoint_next = setpoint_reg;
        refresh       = 1'b0;
        case (state_reg)
            ST_NORMAL: begin
                if (key == KEY_HASH) begin
                    state_next = ST_ENTRY;
                    count_next = '0;
                    valid_next = 1'b1;
                    refresh    = 1'b1;
                end
            end
            ST_ENTRY: begin
                refresh = 1'b1;
                if (!fmt_ok) begin
                    valid_next = 1'b0;
                end else begin
                    case (key)
                        KEY_STAR: count_next = LEN_AFTER_POINT;
                        KEY_A: begin
                            state_next = ST_NORMAL;
                            if (value >= min_reg && value <= max_reg) begin
                                setpoint_next = value;
                            end else begin
                                valid_next = 1'b0;
                            end
                        end
                        KEY_B: begin
                            if (count_reg != '0) begin
                                count_next = count_reg - 3'd1;
                            end
                        end
                        KEY_C: state_next = ST_NORMAL;
                        default: begin
                            digit_next[slot] = key;
                            count_next       = count_reg + 3'd1;
                        end
                    endcase
                end
            end
            default: state_next = ST_NORMAL;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_NORMAL;
            count_reg    <= '0;
            digit_reg    <= '{default: '0};
            valid_reg    <= 1'b1;
            setpoint_reg <= SETPOINT_RST;
        end else if (fire) begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            digit_reg    <= digit_next;
            valid_reg    <= valid_next;
            setpoint_reg <= setpoint_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= MIN_TARGET_RST;
            max_reg <= MAX_TARGET_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MIN_TARGET: min_reg <= cfg_wdata;
                CFG_MAX_TARGET: max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        result.in_entry_mode  = (state_next == ST_ENTRY);
        result.entry_length   = count_next;
        result.tens_digit     = (count_next >= 3'd1) ? digit_next[0] : '0;
        result.units_digit    = (count_next >= 3'd2) ? digit_next[1] : '0;
        result.tenths_digit   = (count_next >= LEN_FULL) ? digit_next[2] : '0;
        result.entry_ok       = valid_next;
        result.target_tenths  = setpoint_next;
        result.display_update = refresh;
    end

endmodule

// ----- design/kse_out_reg.sv -----
// Result register on the master side; it frees up as soon as the result is taken.
module kse_out_reg
    import kse_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load_valid,
    input  kse_result_t          result,
    output logic                 advance,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata
);

    logic        out_valid_reg;
    kse_result_t out_data_reg;

    assign advance = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= load_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && load_valid) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_data_reg);

endmodule

// ----- design/keypad_setpoint_entry.sv -----
// Keypad setpoint entry: top level with the input register and the result stage.
// One key press is taken per transfer on the s_ side and gives exactly one result on the
// m_ side. A press can be taken every cycle: the input and the result register form a
// two-stage pipeline that only stalls when a result is waiting and m_tready is low. The
// entry state is updated as a press moves from the input into the result register. The user
// must write the limits on cfg_ while no press is in flight; the block does not enforce it.
module keypad_setpoint_entry
    import kse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // key_row[1:0], key_column[3:2], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // in_entry_mode[0], entry_length[3:1], tens_digit[7:4], units_digit[11:8],
    // tenths_digit[15:12], entry_ok[16], target_tenths[26:17], display_update[27], zero pad
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    logic        in_valid_reg;
    logic [1:0]  row_reg;
    logic [1:0]  col_reg;
    logic        advance;
    logic        fire;
    kse_result_t result;

    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            row_reg <= s_tdata[1:0];
            col_reg <= s_tdata[3:2];
        end
    end

    kse_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .key_row    (row_reg),
        .key_column (col_reg),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .result     (result)
    );

    kse_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_valid_reg),
        .result     (result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

`ifndef SYNTHESIS
    // an empty result stage must never hold back the input side
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result stage");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:1] <= 3'd4))
        else $error("entry length out of range");

    a_entry_refresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> m_tdata[27])
        else $error("press in entry mode without display refresh");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:4] <= 4'd9 && m_tdata[11:8] <= 4'd9 && m_tdata[15:12] <= 4'd9))
        else $error("digit field above nine");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:28] == 4'd0))
        else $error("result padding not zero");
`endif

endmodule
